>>> src/ctnl_pkg.sv
// Shared types, sizes and codes of the character trie name lookup.
`timescale 1ns / 1ps

package ctnl_pkg;

    // Table sizes.
    localparam int NODES          = 1024;
    localparam int ALPHABET       = 128;
    localparam int MAX_NAMES      = 256;
    localparam int ADDRS_PER_NAME = 8;

    // Field widths of the words.
    localparam int CH_W   = 7;
    localparam int IP_W   = 32;
    localparam int ID_W   = 9;
    localparam int CNT_W  = 4;

    // Derived depths and widths of the stores.
    localparam int CHILD_DEPTH = NODES * ALPHABET;
    localparam int NODE_W      = $clog2(NODES);
    localparam int SLOT_W      = $clog2(CHILD_DEPTH);
    localparam int NAME_W      = $clog2(MAX_NAMES);
    localparam int STORE_DEPTH = MAX_NAMES * ADDRS_PER_NAME;
    localparam int STORE_W     = $clog2(STORE_DEPTH);
    localparam int NODE_WORD_W = ID_W + 1;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2,
        STAT_LIST = 2'd3
    } status_e_t;

    // Walk command of one character.
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } command_t;

    // Input word.
    typedef struct packed {
        logic              command;
        logic [CH_W-1:0]   ch;
        logic              last;
        logic [IP_W-1:0]   ip_address;
    } in_t;

    // Result word.
    typedef struct packed {
        status_e_t         status;
        logic [ID_W-1:0]   name_id;
        logic [CNT_W-1:0]  address_count;
    } out_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHILD,
        S_NODE_RD,
        S_NODE_CHK,
        S_CNT_RD,
        S_CNT_CHK,
        S_FINISH
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic child_step;
        logic node_chk;
        logic cnt_chk;
        logic load_out;
    } ctl_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic last;
        logic broken;
        logic res_ok;
        logic out_free;
    } ctl_stat_t;

endpackage

>>> src/ctnl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ctnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ctnl_ctrl.sv
// Controller state machine that sequences each character and each name end.
`timescale 1ns / 1ps

module ctnl_ctrl import ctnl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHILD;
                end
            end
            S_CHILD: begin
                cmd.child_step = 1'b1;
                state_next     = stat.last ? S_NODE_RD : S_IDLE;
            end
            S_NODE_RD: begin
                state_next = stat.broken ? S_FINISH : S_NODE_CHK;
            end
            S_NODE_CHK: begin
                cmd.node_chk = 1'b1;
                state_next   = S_CNT_RD;
            end
            S_CNT_RD: begin
                state_next = stat.res_ok ? S_CNT_CHK : S_FINISH;
            end
            S_CNT_CHK: begin
                cmd.cnt_chk = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // A result is only produced for the final character of a name.
    a_load_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.last)
        else $error("result loaded for a character that is not last");

    // No word is taken before the tables are cleared.
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) && !stat.clear_done |=> !s_ready)
        else $error("word accepted during the clearing pass");
`endif

endmodule

>>> src/ctnl_dp.sv
// Datapath: walk registers, trie and name tables, address store and result register.
`timescale 1ns / 1ps

module ctnl_dp import ctnl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_t       s_data,
    input  ctl_cmd_t  cmd,
    output ctl_stat_t stat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_t      m_data
);

    // Walk and allocation state.
    logic [NODE_W-1:0]  cur_node_reg, cur_node_next;
    logic [NODE_W-1:0]  nodes_alloc_reg, nodes_alloc_next;
    logic [ID_W-1:0]    names_alloc_reg, names_alloc_next;
    status_e_t          broken_reg, broken_next;
    logic [SLOT_W-1:0]  clr_reg, clr_next;

    // Captured word and per-step flags.
    logic               cmd_reg, cmd_next;
    logic               last_reg, last_next;
    logic [IP_W-1:0]    ip_reg, ip_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               step_reg, step_next;

    // Result being built and output register.
    status_e_t          res_status_reg, res_status_next;
    logic [ID_W-1:0]    res_id_reg, res_id_next;
    logic [CNT_W-1:0]   res_cnt_reg, res_cnt_next;
    out_t               m_data_reg, m_data_next;
    logic               m_valid_reg, m_valid_next;

    // Address store write address, kept for the read-back check.
    logic [STORE_W-1:0] store_wa_reg;

    // Memory ports.
    logic                   child_we;
    logic [SLOT_W-1:0]      child_wa;
    logic [NODE_W-1:0]      child_wd;
    logic [SLOT_W-1:0]      child_ra;
    logic [NODE_W-1:0]      child_rd;
    logic                   node_we;
    logic [NODE_W-1:0]      node_wa;
    logic [NODE_WORD_W-1:0] node_wd;
    logic [NODE_WORD_W-1:0] node_rd;
    logic                   cnt_we;
    logic [NAME_W-1:0]      cnt_wa;
    logic [CNT_W-1:0]       cnt_wd;
    logic [NAME_W-1:0]      cnt_ra;
    logic [CNT_W-1:0]       cnt_rd;
    logic                   store_we;
    logic [STORE_W-1:0]     store_wa;
    logic [IP_W-1:0]        store_wd;
    logic [IP_W-1:0]        store_rd;

    // Helper values.
    logic [SLOT_W-1:0]  slot_c;
    logic               in_range;
    logic               child_ok;
    logic [NODE_W-1:0]  new_node;
    logic               node_full;
    logic [ID_W-1:0]    node_id;
    logic               node_end;
    logic [ID_W-1:0]    res_id_m1;

    assign slot_c    = SLOT_W'(SLOT_W'(cur_node_reg) * SLOT_W'(ALPHABET) + SLOT_W'(s_data.ch));
    assign in_range  = (32'(s_data.ch) < ALPHABET) && (cur_node_reg != '0)
                       && (32'(cur_node_reg) < NODES);
    assign child_ok  = (child_rd != '0) && (32'(child_rd) < NODES);
    assign new_node  = nodes_alloc_reg + NODE_W'(1);
    assign node_full = (32'(nodes_alloc_reg) + 1) >= NODES;
    assign node_id   = node_rd[ID_W-1:0];
    assign node_end  = node_rd[ID_W];
    assign res_id_m1 = res_id_reg - ID_W'(1);

    // Read addresses follow the walk registers.
    assign child_ra = slot_c;
    assign cnt_ra   = res_id_m1[NAME_W-1:0];

    // Status toward the controller.
    assign stat.clear_done = (clr_reg == SLOT_W'(CHILD_DEPTH - 1));
    assign stat.last       = last_reg;
    assign stat.broken     = (broken_reg != STAT_OK);
    assign stat.res_ok     = (res_status_reg == STAT_OK);
    assign stat.out_free   = !m_valid_reg || m_ready;

    // Next values of all datapath registers and memory writes.
    always_comb begin
        cur_node_next    = cur_node_reg;
        nodes_alloc_next = nodes_alloc_reg;
        names_alloc_next = names_alloc_reg;
        broken_next      = broken_reg;
        clr_next         = clr_reg;
        cmd_next         = cmd_reg;
        last_next        = last_reg;
        ip_next          = ip_reg;
        slot_next        = slot_reg;
        step_next        = step_reg;
        res_status_next  = res_status_reg;
        res_id_next      = res_id_reg;
        res_cnt_next     = res_cnt_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        child_we = 1'b0;
        child_wa = slot_reg;
        child_wd = new_node;
        node_we  = 1'b0;
        node_wa  = cur_node_reg;
        node_wd  = {1'b1, names_alloc_reg + ID_W'(1)};
        cnt_we   = 1'b0;
        cnt_wa   = res_id_m1[NAME_W-1:0];
        cnt_wd   = cnt_rd + CNT_W'(1);
        store_we = 1'b0;
        store_wa = STORE_W'(32'(res_id_m1) * ADDRS_PER_NAME + 32'(cnt_rd));
        store_wd = ip_reg;

        // Clearing pass over the child, node and count tables.
        if (cmd.clear) begin
            clr_next = clr_reg + SLOT_W'(1);
            child_we = 1'b1;
            child_wa = clr_reg;
            child_wd = '0;
            if (32'(clr_reg) < NODES) begin
                node_we = 1'b1;
                node_wa = clr_reg[NODE_W-1:0];
                node_wd = '0;
            end
            if (32'(clr_reg) < MAX_NAMES) begin
                cnt_we = 1'b1;
                cnt_wa = clr_reg[NAME_W-1:0];
                cnt_wd = '0;
            end
        end

        // Take a word and check whether its step can look up a child.
        if (cmd.capture) begin
            cmd_next  = s_data.command;
            last_next = s_data.last;
            ip_next   = s_data.ip_address;
            slot_next = slot_c;
            step_next = (broken_reg == STAT_OK) && in_range;
            if ((broken_reg == STAT_OK) && !in_range) begin
                broken_next = (s_data.command == CMD_INSERT) ? STAT_FULL : STAT_MISS;
            end
        end

        // Follow the child, or allocate it on insert.
        if (cmd.child_step && step_reg) begin
            priority if (child_ok) begin
                cur_node_next = child_rd;
            end else if (cmd_reg == CMD_SEARCH) begin
                broken_next = STAT_MISS;
            end else if (node_full) begin
                broken_next = STAT_FULL;
            end else begin
                child_we         = 1'b1;
                nodes_alloc_next = new_node;
                cur_node_next    = new_node;
            end
        end

        // Resolve the name id at the end node.
        if (cmd.node_chk) begin
            res_cnt_next = '0;
            if (cmd_reg == CMD_INSERT) begin
                res_status_next = STAT_OK;
                res_id_next     = node_id;
                if ((node_id == '0) || (32'(node_id) > MAX_NAMES)) begin
                    if (32'(names_alloc_reg) >= MAX_NAMES) begin
                        res_status_next = STAT_FULL;
                        res_id_next     = '0;
                    end else begin
                        names_alloc_next = names_alloc_reg + ID_W'(1);
                        res_id_next      = names_alloc_reg + ID_W'(1);
                        node_we          = 1'b1;
                    end
                end
            end else begin
                if (node_end && (node_id != '0) && (32'(node_id) <= MAX_NAMES)) begin
                    res_status_next = STAT_OK;
                    res_id_next     = node_id;
                end else begin
                    res_status_next = STAT_MISS;
                    res_id_next     = '0;
                end
            end
        end

        // Read the address count and append on insert.
        if (cmd.cnt_chk) begin
            res_cnt_next = cnt_rd;
            if (cmd_reg == CMD_INSERT) begin
                if (32'(cnt_rd) >= ADDRS_PER_NAME) begin
                    res_status_next = STAT_LIST;
                end else begin
                    cnt_we       = 1'b1;
                    store_we     = 1'b1;
                    res_cnt_next = cnt_rd + CNT_W'(1);
                end
            end
        end

        // Load the result word and return the walk to the root.
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
            if (broken_reg != STAT_OK) begin
                m_data_next.status        = broken_reg;
                m_data_next.name_id       = '0;
                m_data_next.address_count = '0;
            end else begin
                m_data_next.status        = res_status_reg;
                m_data_next.name_id       = res_id_reg;
                m_data_next.address_count = res_cnt_reg;
            end
            cur_node_next = NODE_W'(1);
            broken_next   = STAT_OK;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_node_reg    <= NODE_W'(1);
            nodes_alloc_reg <= NODE_W'(1);
            names_alloc_reg <= '0;
            broken_reg      <= STAT_OK;
            clr_reg         <= '0;
            step_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            cur_node_reg    <= cur_node_next;
            nodes_alloc_reg <= nodes_alloc_next;
            names_alloc_reg <= names_alloc_next;
            broken_reg      <= broken_next;
            clr_reg         <= clr_next;
            step_reg        <= step_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        last_reg       <= last_next;
        ip_reg         <= ip_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_cnt_reg    <= res_cnt_next;
        m_data_reg     <= m_data_next;
        store_wa_reg   <= store_wa;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Child table: child node per node and character.
    ctnl_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child_ram (
        .aclk  (aclk),
        .we    (child_we),
        .waddr (child_wa),
        .wdata (child_wd),
        .raddr (child_ra),
        .rdata (child_rd)
    );

    // Node table: end mark and name id per node.
    ctnl_ram #(.WIDTH(NODE_WORD_W), .DEPTH(NODES)) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_wa),
        .wdata (node_wd),
        .raddr (cur_node_reg),
        .rdata (node_rd)
    );

    // Address count per name id.
    ctnl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NAMES)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_wa),
        .wdata (cnt_wd),
        .raddr (cnt_ra),
        .rdata (cnt_rd)
    );

    // Address store; read back at the registered write address.
    ctnl_ram #(.WIDTH(IP_W), .DEPTH(STORE_DEPTH)) u_store_ram (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_wa),
        .wdata (store_wd),
        .raddr (store_wa_reg),
        .rdata (store_rd)
    );

`ifndef SYNTHESIS
    // The walk never stands on a node that has not been allocated.
    a_cur_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_node_reg != '0) && (cur_node_reg <= nodes_alloc_reg))
        else $error("walk on an unallocated node");

    // A stored count never exceeds the list size.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we && !cmd.clear |-> (32'(cnt_wd) <= ADDRS_PER_NAME))
        else $error("address count beyond the list size");

    // An appended address reads back from the store at the registered write address.
    a_store_back: assert property (@(posedge aclk) disable iff (!aresetn)
        store_we |=> ##1 (store_rd == $past(store_wd, 2)))
        else $error("address store read-back mismatch");
`endif

endmodule

>>> src/character_trie_name_lookup.sv
// Top level of the character trie name lookup: controller plus datapath.
`timescale 1ns / 1ps

// Channel   Direction  Word    Handshake
// s_        in         in_t    s_valid / s_ready, one character per word
// m_        out        out_t   m_valid / m_ready, one result per name
//
// For each character the word is taken and its child-table read is issued, then the
// child is followed or allocated from the registered read data. The last character
// of a name goes on through the node table, the count table and the result. A broken
// walk skips both checks; a search miss or a full name table skips the count check.
// After reset, clearing all NODES * ALPHABET (131072) child entries precedes s_ready.
// A result waiting on m_ready holds back only the next name end, not its characters.

module character_trie_name_lookup import ctnl_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // Sequencer.
    ctnl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Tables, walk registers and output register.
    ctnl_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the character trie name lookup: stimulus, trie predictor, checks.
`timescale 1ns / 1ps

module tb_top;
    import ctnl_pkg::*;

    localparam int MAX_LEN          = 24;
    localparam int POOL_SIZE        = 64;
    localparam int RANDOM_WORDS     = 250;
    localparam int PRESSURE_AT_NAME = 40;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 20;
    localparam int LIMIT_CYCLES     = 1_500_000;
    localparam logic [CH_W-1:0] LOWER_A = 7'd97;
    localparam logic [CH_W-1:0] LOWER_B = 7'd98;
    localparam logic [CH_W-1:0] LOWER_Q = 7'd113;
    localparam logic [CH_W-1:0] LOWER_R = 7'd114;
    localparam logic [CH_W-1:0] LOWER_X = 7'd120;
    localparam logic [CH_W-1:0] LOWER_Y = 7'd121;
    localparam logic [CH_W-1:0] LOWER_Z = 7'd122;
    localparam logic [CH_W-1:0] CH_MAX  = 7'd127;
    localparam logic [IP_W-1:0] IP_ONES = 32'hFFFF_FFFF;

    // Trie predictor: mirrors the child table, end marks, ids and address counts.
    class trie_tracker;
        bit [NODE_W-1:0] child_of [CHILD_DEPTH];
        bit              end_mark [NODES];
        bit [ID_W-1:0]   node_id [NODES];
        int              addr_count [MAX_NAMES];
        int              walk_node = 1;
        status_e_t       walk_status = STAT_OK;
        int              nodes_used = 1;
        int              names_used = 0;
        int              node_full_hits = 0;
        int              name_full_hits = 0;
        int              list_full_hits = 0;
        int              results_seen = 0;
        int              mismatches = 0;
        out_t            pending_results[$];

        // Follow or allocate one child edge of the walk.
        function void walk_char(command_t cmd, int c);
            int slot;
            int kid;
            if (walk_status != STAT_OK) return;
            if (c >= ALPHABET || walk_node == 0 || walk_node >= NODES) begin
                walk_status = (cmd == CMD_INSERT) ? STAT_FULL : STAT_MISS;
                return;
            end
            slot = walk_node * ALPHABET + c;
            kid = child_of[slot];
            if (kid != 0 && kid < NODES) begin
                walk_node = kid;
                return;
            end
            if (cmd != CMD_INSERT) begin
                walk_status = STAT_MISS;
                return;
            end
            if (nodes_used + 1 >= NODES) begin
                walk_status = STAT_FULL;
                node_full_hits++;
                return;
            end
            nodes_used++;
            child_of[slot] = nodes_used[NODE_W-1:0];
            walk_node = nodes_used;
        endfunction

        // Take one accepted word; a last word queues the result it must produce.
        function void take_char(in_t w);
            command_t  cmd;
            status_e_t st;
            int        id;
            int        cnt;
            out_t      r;
            cmd = command_t'(w.command);
            walk_char(cmd, int'(w.ch));
            if (!w.last) return;
            st = STAT_OK;
            id = 0;
            cnt = 0;
            if (walk_status != STAT_OK) begin
                st = walk_status;
            end else if (cmd == CMD_INSERT) begin
                id = node_id[walk_node];
                if (id == 0 || id > MAX_NAMES) begin
                    if (names_used >= MAX_NAMES) begin
                        st = STAT_FULL;
                        id = 0;
                        name_full_hits++;
                    end else begin
                        names_used++;
                        id = names_used;
                        node_id[walk_node] = id[ID_W-1:0];
                        end_mark[walk_node] = 1'b1;
                    end
                end
                if (st == STAT_OK) begin
                    cnt = addr_count[id-1];
                    if (cnt >= ADDRS_PER_NAME) begin
                        st = STAT_LIST;
                        list_full_hits++;
                    end else begin
                        cnt++;
                        addr_count[id-1] = cnt;
                    end
                end
            end else begin
                id = node_id[walk_node];
                if (end_mark[walk_node] && id != 0 && id <= MAX_NAMES) begin
                    cnt = addr_count[id-1];
                end else begin
                    st = STAT_MISS;
                    id = 0;
                end
            end
            walk_node = 1;
            walk_status = STAT_OK;
            r.status = st;
            r.name_id = id[ID_W-1:0];
            r.address_count = cnt[CNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        // Compare one accepted result word with the oldest expected one.
        function void check_result(out_t got);
            out_t want;
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("Unexpected result %0d: status %0d id %0d count %0d",
                    results_seen, got.status, got.name_id, got.address_count));
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.name_id !== want.name_id ||
                got.address_count !== want.address_count) begin
                note_mismatch($sformatf(
                    "Result %0d differs: expected status %0d id %0d count %0d, got %0d %0d %0d",
                    results_seen, want.status, want.name_id, want.address_count,
                    got.status, got.name_id, got.address_count));
            end
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    trie_tracker tracker = new;

    bit calm      = 1'b0;
    bit hold_sink = 1'b0;
    int words_sent = 0;
    int names_sent = 0;
    logic [CH_W-1:0] name_buf [MAX_LEN];
    logic [CH_W-1:0] pool_chars [POOL_SIZE][MAX_LEN];
    int pool_len [POOL_SIZE];
    int pool_n = 0;

    character_trie_name_lookup DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock with a 10 ns period.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Idle length for either side: mostly none or short, a few long.
    function automatic int idle_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly a small alphabet so names share prefixes and repeat.
    function automatic logic [CH_W-1:0] pick_char();
        if ($urandom_range(0, 99) < 85) return LOWER_A + CH_W'($urandom_range(0, 3));
        return CH_W'($urandom_range(0, ALPHABET - 1));
    endfunction

    function automatic void random_name(int len, bit full_range);
        for (int i = 0; i < len; i++) begin
            name_buf[i] = full_range ? CH_W'($urandom_range(0, ALPHABET - 1)) : pick_char();
        end
    endfunction

    function automatic void remember_name(int len);
        int slot;
        slot = (pool_n < POOL_SIZE) ? pool_n : $urandom_range(0, POOL_SIZE - 1);
        if (pool_n < POOL_SIZE) pool_n++;
        for (int i = 0; i < len; i++) pool_chars[slot][i] = name_buf[i];
        pool_len[slot] = len;
    endfunction

    // Load a known name, or a proper prefix of it, into the name buffer.
    function automatic int recall_name(bit prefix);
        int slot;
        int len;
        slot = $urandom_range(0, pool_n - 1);
        len = pool_len[slot];
        if (prefix && len > 1) len = $urandom_range(1, len - 1);
        for (int i = 0; i < len; i++) name_buf[i] = pool_chars[slot][i];
        return len;
    endfunction

    // Offer one word, hold it until accepted, then maybe pause.
    task automatic send_word(input in_t w);
        int gap;
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_char(w);
        words_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic put(input command_t cmd, input logic [CH_W-1:0] c, input logic last,
                       input logic [IP_W-1:0] ip);
        in_t w;
        w.command = cmd;
        w.ch = c;
        w.last = last;
        w.ip_address = ip;
        send_word(w);
    endtask

    // Send the name in the buffer; a mixed name picks each character's command at random.
    task automatic send_name(input int len, input command_t cmd, input bit mixed);
        command_t c;
        for (int i = 0; i < len; i++) begin
            c = mixed ? command_t'($urandom_range(0, 1)) : cmd;
            put(c, name_buf[i], i == len - 1, $urandom);
        end
        names_sent++;
    endtask

    // One random operation: repeats, new names, hits, prefixes, misses, mixed commands.
    task automatic random_name_op();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
        if (pick < 35 && pool_n > 0) begin
            len = recall_name(1'b0);
            send_name(len, CMD_INSERT, 1'b0);
        end else if (pick < 55) begin
            random_name(len, 1'b0);
            remember_name(len);
            send_name(len, CMD_INSERT, 1'b0);
        end else if (pick < 85 && pool_n > 0) begin
            len = recall_name($urandom_range(0, 4) == 0);
            send_name(len, CMD_SEARCH, 1'b0);
        end else if (pick < 93) begin
            random_name(len, $urandom_range(0, 1));
            send_name(len, CMD_SEARCH, 1'b0);
        end else begin
            if (pool_n > 0 && $urandom_range(0, 1)) len = recall_name(1'b0);
            else random_name(len, 1'b0);
            send_name(len, CMD_INSERT, 1'b1);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int pause;
        @(posedge aclk);
        forever begin
            if (hold_sink) begin
                hold_sink = 1'b0;
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
            end else begin
                pause = idle_gap();
                if (pause > 0) begin
                    m_ready <= 1'b0;
                    repeat (pause) @(posedge aclk);
                end else begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end
            end
        end
    end

    // Check every accepted result word.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_data);
    end

    // Hard limit on the run.
    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("Timeout with %0d results still expected", tracker.pending_results.size());
        $display("Mismatches found");
        $finish;
    end

    // Stimulus: directed cases, random names, then filling the name table.
    initial begin : stimulus
        int guard;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Nine inserts of one name: the last finds its address list full.
        put(CMD_INSERT, '0, 1'b1, IP_ONES);
        put(CMD_INSERT, '0, 1'b1, '0);
        repeat (7) put(CMD_INSERT, '0, 1'b1, $urandom);
        // Highest character, then a hit and a miss on single characters.
        put(CMD_INSERT, CH_MAX, 1'b1, IP_ONES);
        put(CMD_SEARCH, CH_MAX, 1'b1, '0);
        put(CMD_SEARCH, LOWER_B, 1'b1, $urandom);
        // A prefix with no end mark is a miss.
        put(CMD_INSERT, LOWER_X, 1'b0, $urandom);
        put(CMD_INSERT, LOWER_Y, 1'b0, $urandom);
        put(CMD_INSERT, LOWER_Z, 1'b1, $urandom);
        put(CMD_SEARCH, LOWER_X, 1'b0, $urandom);
        put(CMD_SEARCH, LOWER_Y, 1'b1, $urandom);
        // Mixed commands: search steps ending in an insert, insert steps ending in a search.
        put(CMD_SEARCH, LOWER_X, 1'b0, $urandom);
        put(CMD_SEARCH, LOWER_Y, 1'b0, $urandom);
        put(CMD_INSERT, LOWER_Z, 1'b1, $urandom);
        put(CMD_INSERT, LOWER_X, 1'b0, $urandom);
        put(CMD_SEARCH, LOWER_Y, 1'b1, $urandom);
        // A broken search walk stays broken even when the name ends as an insert.
        put(CMD_SEARCH, LOWER_Q, 1'b0, $urandom);
        put(CMD_INSERT, LOWER_R, 1'b1, $urandom);
        put(CMD_SEARCH, '0, 1'b1, $urandom);

        // Random names; one long result stall partway through.
        while (words_sent < RANDOM_WORDS) begin
            if (names_sent % 30 == 0) calm = ($urandom_range(0, 3) == 0);
            if (names_sent == PRESSURE_AT_NAME) hold_sink = 1'b1;
            random_name_op();
        end

        // Every single character as a name, then two-character names past the id limit.
        calm = 1'b0;
        for (int c = 0; c < ALPHABET; c++) begin
            name_buf[0] = CH_W'(c);
            send_name(1, CMD_INSERT, 1'b0);
        end
        guard = 0;
        while (tracker.names_used < MAX_NAMES && guard < 600) begin
            random_name(2, 1'b1);
            send_name(2, CMD_INSERT, 1'b0);
            guard++;
        end
        repeat (4) begin
            random_name(2, 1'b1);
            send_name(2, CMD_INSERT, 1'b0);
        end

        // More random traffic against the full name table.
        repeat (40) begin
            if (names_sent % 20 == 0) calm = ($urandom_range(0, 3) == 0);
            random_name_op();
        end

        s_valid <= 1'b0;
        while (tracker.pending_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters in %0d names; %0d results compared.",
                 words_sent, names_sent, tracker.results_seen);
        $display("Table limits reached: node %0d times, name id %0d, address list %0d.",
                 tracker.node_full_hits, tracker.name_full_hits, tracker.list_full_hits);
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
